@@ hdl/btp_pkg.sv @@
// Shared types and constants for the binary thinning pass core.
// No dependencies; imported by btp_kernel and binary_thinning_pass_core.
package btp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 13;             // holds height + 1
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CNT_W      = 24;

    localparam logic [WCFG_W-1:0] WIDTH_MIN   = WCFG_W'(3);
    localparam logic [WCFG_W-1:0] WIDTH_MAX   = WCFG_W'(MAX_WIDTH);
    localparam logic [WCFG_W-1:0] WIDTH_RST   = WCFG_W'(50);
    localparam logic [HCFG_W-1:0] HEIGHT_MIN  = HCFG_W'(3);
    localparam logic [HCFG_W-1:0] HEIGHT_MAX  = HCFG_W'(MAX_HEIGHT);
    localparam logic [HCFG_W-1:0] HEIGHT_RST  = HCFG_W'(42);
    localparam logic [CNT_W-1:0]  COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [7:0]        PIX_FULL    = 8'd255;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // command carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [7:0] pix_t;
    // 3x3 window, [row][col], row 0 = north, col 0 = west
    typedef logic [2:0][2:0][7:0] win_t;

    // item held between acceptance and the window update
    typedef struct packed {
        pix_t             pix;
        logic [COL_W-1:0] col;
        logic             emit;      // produces a result transaction
        logic             last;
        logic             interior;
    } stage_t;

endpackage

@@ hdl/btp_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module btp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/btp_kernel.sv @@
// Zhang-Suen deletion test on a 3x3 window, both subiterations ORed.
// Depends on btp_pkg.
module btp_kernel (
    input  btp_pkg::win_t win,
    output logic          deletable
);
    import btp_pkg::*;

    logic       n, ne, e, se, s, sw, w, nw;
    logic [7:0] ring;
    logic [3:0] trans;
    logic [3:0] fg;
    logic       first_ok, second_ok;

    always_comb begin
        n  = win[0][1] != '0;
        ne = win[0][2] != '0;
        e  = win[1][2] != '0;
        se = win[2][2] != '0;
        s  = win[2][1] != '0;
        sw = win[2][0] != '0;
        w  = win[1][0] != '0;
        nw = win[0][0] != '0;
        // clockwise from north
        ring  = {nw, w, sw, s, se, e, ne, n};
        trans = '0;
        fg    = '0;
        for (int k = 0; k < 8; k++) begin
            trans = trans + 4'(!ring[k] && ring[(k + 1) % 8]);
            fg    = fg + 4'(ring[k]);
        end
        first_ok  = !(n && e && s) && !(e && s && w);
        second_ok = !(n && e && w) && !(n && s && w);
        deletable = (trans == 4'd1) && (fg >= 4'd2) && (fg <= 4'd6)
                    && (first_ok || second_ok);
    end

endmodule

@@ hdl/binary_thinning_pass_core.sv @@
// Top level of the binary thinning pass: line buffers, 3x3 window, output register.
// Depends on btp_pkg, btp_ram and btp_kernel.
//
//  channel | direction | payload (lowest bit first)
//  --------+-----------+----------------------------------------------
//  s_*     | in        | tdata: pixel_value[7:0]; tuser: cmd
//  m_*     | out       | tdata: out_pixel[7:0], deleted_count[31:8]; tlast
//  cfg_*   | in        | index 0 image_width, index 1 image_height
//
// One transaction per clock sustained while m_tready stays high. An item is
// registered together with its two line-buffer reads, then the window shift and
// deletion test run straight into the output register when it can take the item;
// the line-buffer RAMs have a registered read. Reset is synchronous, active low;
// the line buffers are not cleared. A stalled m_tready holds the output register
// and the item behind it; s_tready drops only when both are full.
module binary_thinning_pass_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // pixel_value[7:0]
    input  logic [0:0]  s_tuser,    // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_pixel[7:0], deleted_count[31:8]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_wdata
);
    import btp_pkg::*;

    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  del_cnt_reg, del_cnt_next;
    stage_t            a_reg, a_next;
    logic              a_valid_reg;
    win_t              win_reg, win_next;
    logic              m_valid_reg;
    pix_t              m_pix_reg;
    logic              m_last_reg;
    logic [CNT_W-1:0]  m_cnt_reg;

    logic              s_acc, in_image, drop, load, adv;
    logic [WCFG_W-1:0] col_inc;
    logic [WCFG_W-1:0] wval;
    logic [HCFG_W-1:0] hval;
    pix_t              top_pix, mid_pix;
    logic              deletable, del;
    logic [CNT_W-1:0]  cnt_after;
    pix_t              centre;

    // line buffers: top row and middle row, same column address
    btp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_ram (
        .aclk  (aclk),
        .we    (adv && a_valid_reg),
        .waddr (a_reg.col),
        .wdata (mid_pix),
        .re    (load),
        .raddr (col_reg),
        .rdata (top_pix)
    );

    btp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .aclk  (aclk),
        .we    (adv && a_valid_reg),
        .waddr (a_reg.col),
        .wdata (a_reg.pix),
        .re    (load),
        .raddr (col_reg),
        .rdata (mid_pix)
    );

    btp_kernel u_kernel (
        .win       (win_next),
        .deletable (deletable)
    );

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || adv;
    assign s_acc    = s_tvalid && s_tready;
    assign in_image = row_reg < ROW_W'(height_reg);
    assign drop     = (s_tuser[0] == CMD_FLUSH) && in_image;
    assign load     = s_acc && !drop;
    assign col_inc  = WCFG_W'(col_reg) + WCFG_W'(1);

    always_comb begin
        wval = cfg_wdata[WCFG_W-1:0];
        if (wval < WIDTH_MIN) begin
            wval = WIDTH_MIN;
        end else if (wval > WIDTH_MAX) begin
            wval = WIDTH_MAX;
        end
        hval = cfg_wdata[HCFG_W-1:0];
        if (hval < HEIGHT_MIN) begin
            hval = HEIGHT_MIN;
        end else if (hval > HEIGHT_MAX) begin
            hval = HEIGHT_MAX;
        end
    end

    // acceptance side: stream position and item classification
    always_comb begin
        a_next.pix      = in_image ? s_tdata : '0;
        a_next.col      = col_reg;
        a_next.emit     = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_reg != '0);
        a_next.last     = (row_reg == ROW_W'(height_reg) + ROW_W'(1)) && (col_reg == '0);
        a_next.interior = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2))
                          && (row_reg <= ROW_W'(height_reg) - ROW_W'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (load) begin
            if (a_next.last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= width_reg) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // window shift and deletion decision
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_pix;
        win_next[1][2] = mid_pix;
        win_next[2][2] = a_reg.pix;
        centre = win_next[1][1];
        del = a_reg.interior && (centre == PIX_FULL) && deletable;
        cnt_after = (del && del_cnt_reg != COUNT_MAX) ? del_cnt_reg + CNT_W'(1)
                                                      : del_cnt_reg;
        del_cnt_next = a_reg.last ? '0 : cnt_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            col_reg     <= '0;
            row_reg     <= '0;
            del_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            if (cfg_we) begin
                // a register write restarts the frame
                if (cfg_index[0] == REG_WIDTH) begin
                    width_reg <= wval;
                end else begin
                    height_reg <= hval;
                end
                col_reg     <= '0;
                row_reg     <= '0;
                del_cnt_reg <= '0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (adv && a_valid_reg && a_reg.emit) begin
                    del_cnt_reg <= del_cnt_next;
                end
            end
            if (s_tready) begin
                a_valid_reg <= load;
            end
            if (adv) begin
                m_valid_reg <= a_valid_reg && a_reg.emit;
                if (a_valid_reg) begin
                    win_reg <= win_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= a_next;
        end
        if (adv && a_valid_reg) begin
            m_pix_reg  <= del ? '0 : centre;
            m_last_reg <= a_reg.last;
            m_cnt_reg  <= a_reg.last ? cnt_after : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_cnt_reg, m_pix_reg};
    assign m_tlast  = m_last_reg;

endmodule
